>>> hw/rtl/gcb_pkg.sv
// shared types, property codes and pair tables for the grapheme cluster break detector
// no dependencies; used by gcb_rules and the top level
package gcb_pkg;

  localparam int unsigned PROP_COUNT = 21;
  localparam int unsigned PROP_W     = 5;
  localparam int unsigned ROW_W      = 1 << PROP_W;

  typedef logic [PROP_W-1:0] prop_t;
  typedef logic [ROW_W-1:0]  row_t;

  localparam prop_t P_OTHER        = 5'd0;
  localparam prop_t P_CONTROL      = 5'd1;
  localparam prop_t P_CR           = 5'd2;
  localparam prop_t P_EXTEND       = 5'd3;
  localparam prop_t P_EXT_PICT     = 5'd4;
  localparam prop_t P_HL           = 5'd5;
  localparam prop_t P_HV           = 5'd6;
  localparam prop_t P_HT           = 5'd7;
  localparam prop_t P_HLV          = 5'd8;
  localparam prop_t P_HLVT         = 5'd9;
  localparam prop_t P_LF           = 5'd10;
  localparam prop_t P_PREPEND      = 5'd11;
  localparam prop_t P_RI           = 5'd12;
  localparam prop_t P_SPACING      = 5'd13;
  localparam prop_t P_ZWJ          = 5'd14;
  localparam prop_t P_ICB_CONS     = 5'd15;
  localparam prop_t P_ICB_EXT      = 5'd16;
  localparam prop_t P_ICB_LINK     = 5'd17;
  localparam prop_t P_EXT_ICB_EXT  = 5'd18;
  localparam prop_t P_EXT_ICB_LINK = 5'd19;
  localparam prop_t P_ZWJ_ICB_EXT  = 5'd20;

  localparam row_t ALL_SET = 32'hFFFF_FFFF;

  localparam row_t EXT_SET = (row_t'(1) << P_EXTEND) | (row_t'(1) << P_EXT_ICB_EXT)
                           | (row_t'(1) << P_EXT_ICB_LINK) | (row_t'(1) << P_ZWJ)
                           | (row_t'(1) << P_ZWJ_ICB_EXT);
  localparam row_t GB9_SET = EXT_SET | (row_t'(1) << P_SPACING);

  typedef enum logic [1:0] {
    LVL_NONE   = 2'd0,
    LVL_CONS   = 2'd1,
    LVL_EXT    = 2'd2,
    LVL_LINKED = 2'd3
  } conj_level_e;

  typedef struct packed {
    prop_t       prop;
    logic        valid;
    logic        zwj_flag;
    logic        ri_flag;
    conj_level_e level;
  } gcb_state_t;

  // right-hand properties that never break after left property a (GB3, GB6-GB9b)
  function automatic row_t keep_row(prop_t a);
    row_t r;
    r = '0;
    case (a)
      P_CR:      r = row_t'(1) << P_LF;
      P_HL:      r = GB9_SET | (row_t'(1) << P_HL) | (row_t'(1) << P_HV)
                   | (row_t'(1) << P_HLV) | (row_t'(1) << P_HLVT);
      P_HV,
      P_HLV:     r = GB9_SET | (row_t'(1) << P_HV) | (row_t'(1) << P_HT);
      P_HT,
      P_HLVT:    r = GB9_SET | (row_t'(1) << P_HT);
      P_PREPEND: r = GB9_SET | (ALL_SET & ~((row_t'(1) << P_CR) | (row_t'(1) << P_LF)
                                           | (row_t'(1) << P_CONTROL)));
      P_OTHER, P_EXTEND, P_EXT_PICT, P_RI, P_SPACING, P_ZWJ, P_ICB_CONS, P_ICB_EXT,
      P_ICB_LINK, P_EXT_ICB_EXT, P_EXT_ICB_LINK, P_ZWJ_ICB_EXT:
                 r = GB9_SET;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/gcb_rules.sv
// break rule evaluation and context update for one code point
// depends on gcb_pkg
module gcb_rules (
  input  gcb_pkg::gcb_state_t state_i,
  input  gcb_pkg::prop_t      prop_i,
  input  logic                restart_i,
  output gcb_pkg::gcb_state_t state_o,
  output logic                break_o
);

  gcb_pkg::prop_t         a;
  gcb_pkg::prop_t         b;
  gcb_pkg::row_t          rbit;
  gcb_pkg::row_t          row;
  logic                   b_ext;
  logic                   a_zwj;
  logic                   a_icb_ext;
  logic                   a_icb_link;
  logic                   zf;
  logic                   rf;
  logic                   keep;
  gcb_pkg::conj_level_e   lvl;

  always_comb begin
    // codes beyond the property list behave as other
    b = ({1'b0, prop_i} < 6'(gcb_pkg::PROP_COUNT)) ? prop_i : gcb_pkg::P_OTHER;
    a = state_i.prop;
    rbit = gcb_pkg::row_t'(1) << b;
    row  = gcb_pkg::keep_row(a);
    b_ext = (rbit & gcb_pkg::EXT_SET) != '0;
    a_zwj = (a == gcb_pkg::P_ZWJ) || (a == gcb_pkg::P_ZWJ_ICB_EXT);
    a_icb_ext = (a == gcb_pkg::P_ICB_EXT) || (a == gcb_pkg::P_ZWJ_ICB_EXT)
             || (a == gcb_pkg::P_EXT_ICB_EXT);
    a_icb_link = (a == gcb_pkg::P_ICB_LINK) || (a == gcb_pkg::P_EXT_ICB_LINK);

    // emoji zwj context
    if (!state_i.zwj_flag) begin
      zf = (a == gcb_pkg::P_EXT_PICT) && b_ext;
    end else if (a_zwj) begin
      zf = (b == gcb_pkg::P_EXT_PICT);
    end else if ((a == gcb_pkg::P_EXTEND) || (a == gcb_pkg::P_EXT_ICB_EXT)
              || (a == gcb_pkg::P_EXT_ICB_LINK) || (a == gcb_pkg::P_EXT_PICT)) begin
      zf = b_ext;
    end else begin
      zf = 1'b0;
    end

    rf = !state_i.ri_flag && (a == gcb_pkg::P_RI) && (b == gcb_pkg::P_RI);

    // conjunct level follows the left property
    if (a == gcb_pkg::P_ICB_CONS) begin
      lvl = gcb_pkg::LVL_CONS;
    end else if (a_icb_ext) begin
      case (state_i.level)
        gcb_pkg::LVL_NONE:   lvl = gcb_pkg::LVL_NONE;
        gcb_pkg::LVL_LINKED: lvl = gcb_pkg::LVL_LINKED;
        default:             lvl = gcb_pkg::LVL_EXT;
      endcase
    end else if (a_icb_link) begin
      lvl = (state_i.level == gcb_pkg::LVL_NONE) ? gcb_pkg::LVL_NONE : gcb_pkg::LVL_LINKED;
    end else begin
      lvl = gcb_pkg::LVL_NONE;
    end

    keep = row[b]
        || ((lvl == gcb_pkg::LVL_LINKED) && (b == gcb_pkg::P_ICB_CONS))
        || (zf && a_zwj && (b == gcb_pkg::P_EXT_PICT))
        || rf;

    state_o.prop  = b;
    state_o.valid = 1'b1;
    if (!state_i.valid || restart_i) begin
      state_o.zwj_flag = 1'b0;
      state_o.ri_flag  = 1'b0;
      state_o.level    = gcb_pkg::LVL_NONE;
      break_o          = 1'b1;
    end else begin
      state_o.zwj_flag = zf && keep;
      state_o.ri_flag  = rf && keep;
      state_o.level    = lvl;
      break_o          = !keep;
    end
  end

endmodule

>>> hw/rtl/grapheme_cluster_break_detector_unit.sv
// top level of the grapheme cluster break detector: input stage, rule logic, result register
// depends on gcb_pkg and gcb_rules
//
// Usage:
//   Input channel: in_valid_i / in_ready_o carry one code point per transaction as
//   next_prop_i (dense break property code) and restart_i (1 starts a new text).
//   Output channel: out_valid_o / out_ready_i carry break_before_o, one result for
//   each input transaction, in order.
//   A code point passes through the input register, then the result register, before
//   its result is presented.
//   Throughput is one code point per cycle unless the receiver stalls; the rule logic
//   and the context update sit in a single combinational stage between the two registers.
//   The first code point after reset, or one with restart_i set, always reports a
//   boundary and clears the emoji, regional indicator and conjunct context.
//   Reset empties both stages and clears the context; no clearing pass is needed.
//   When the receiver stalls, the result register holds its value and the input
//   register keeps one more transaction, after which in_ready_o drops until the
//   output is taken.
module grapheme_cluster_break_detector_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [4:0]            next_prop_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  break_before_o
);

  logic                s1_valid_q;
  gcb_pkg::prop_t      s1_prop_q;
  logic                s1_restart_q;
  logic                out_valid_q;
  logic                out_break_q;
  gcb_pkg::gcb_state_t state_q;
  gcb_pkg::gcb_state_t state_d;
  logic                break_d;
  logic                advance;
  logic                in_accept;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  gcb_rules u_rules (
    .state_i   (state_q),
    .prop_i    (s1_prop_q),
    .restart_i (s1_restart_q),
    .state_o   (state_d),
    .break_o   (break_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_prop_q    <= next_prop_i;
      s1_restart_q <= restart_i;
    end
    if (advance) begin
      out_break_q <= break_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign break_before_o = out_break_q;

endmodule

>>> hw/rtl/gcb_checker.sv
// port-level checks for grapheme_cluster_break_detector_unit
// bound to the top level; no package dependencies
module gcb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic break_before_o
);

  // a stalled result stays presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(break_before_o))
    else $error("result changed while stalled");

  // input only backs up when the output is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a fresh result comes from an input transaction that went straight through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transaction");

endmodule

bind grapheme_cluster_break_detector_unit gcb_checker u_gcb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .break_before_o (break_before_o)
);

>>> tb/grapheme_cluster_break_detector_unit_test.sv
`timescale 1ns / 1ps
// testbench for grapheme_cluster_break_detector_unit: a directed table, then random code point streams
// depends on gcb_pkg and the rtl; each result is checked against a rule predictor or a table override
module grapheme_cluster_break_detector_unit_test;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned CALM_FIRST   = 900;
  localparam int unsigned CALM_LAST    = 1300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RESTART_PCT  = 3;

  // where the expected boundary of an item comes from
  typedef enum logic [1:0] {
    EXP_MODEL = 2'd0,
    EXP_BREAK = 2'd1,
    EXP_JOIN  = 2'd2
  } exp_src_e;

  typedef struct packed {
    gcb_pkg::prop_t prop;
    logic           restart;
    exp_src_e       src;
  } cp_item_t;

  localparam int unsigned DIRECTED_LEN = 27;
  localparam cp_item_t DIRECTED [DIRECTED_LEN] = '{
    '{gcb_pkg::P_OTHER,          1'b0, EXP_BREAK},  // first code point after reset
    '{gcb_pkg::P_EXTEND,         1'b0, EXP_JOIN},
    '{gcb_pkg::P_CR,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_LF,             1'b0, EXP_JOIN},
    '{gcb_pkg::prop_t'(31),      1'b1, EXP_BREAK},  // restart with the top code, read as other
    '{gcb_pkg::P_PREPEND,        1'b0, EXP_MODEL},
    '{gcb_pkg::P_HL,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_HV,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_HT,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_HLV,            1'b0, EXP_MODEL},
    '{gcb_pkg::P_HLVT,           1'b0, EXP_MODEL},
    '{gcb_pkg::P_EXT_PICT,       1'b0, EXP_MODEL},
    '{gcb_pkg::P_EXT_ICB_EXT,    1'b0, EXP_MODEL},
    '{gcb_pkg::P_ZWJ_ICB_EXT,    1'b0, EXP_MODEL},
    '{gcb_pkg::P_EXT_PICT,       1'b0, EXP_MODEL},
    '{gcb_pkg::P_RI,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_RI,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_RI,             1'b0, EXP_MODEL},
    '{gcb_pkg::P_ICB_CONS,       1'b0, EXP_MODEL},
    '{gcb_pkg::P_EXT_ICB_LINK,   1'b0, EXP_MODEL},
    '{gcb_pkg::P_ICB_EXT,        1'b0, EXP_MODEL},
    '{gcb_pkg::P_ICB_CONS,       1'b0, EXP_MODEL},
    '{gcb_pkg::P_ICB_LINK,       1'b0, EXP_MODEL},
    '{gcb_pkg::P_ZWJ,            1'b0, EXP_MODEL},
    '{gcb_pkg::P_SPACING,        1'b0, EXP_MODEL},
    '{gcb_pkg::P_CONTROL,        1'b0, EXP_MODEL},
    '{gcb_pkg::prop_t'(21),      1'b0, EXP_MODEL}
  };

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  gcb_pkg::prop_t next_prop_i;
  logic           restart_i;
  logic           out_valid_o;
  logic           out_ready_i;
  logic           break_before_o;
  exp_src_e       feed_src;

  cp_item_t    stim_q[$];
  logic        break_q[$];
  int unsigned total_items;
  int unsigned n_accepted;
  int unsigned n_cycles;
  int unsigned n_errors;

  // context of the text seen so far
  gcb_pkg::prop_t       last_prop;
  logic                 last_valid;
  logic                 zwj_open;
  logic                 ri_open;
  gcb_pkg::conj_level_e conj_lvl;

  grapheme_cluster_break_detector_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .next_prop_i    (next_prop_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .break_before_o (break_before_o)
  );

  function automatic logic extend_like(gcb_pkg::prop_t p);
    return p inside {gcb_pkg::P_EXTEND, gcb_pkg::P_EXT_ICB_EXT, gcb_pkg::P_EXT_ICB_LINK,
                     gcb_pkg::P_ZWJ, gcb_pkg::P_ZWJ_ICB_EXT};
  endfunction

  // pairs held together by the plain pair rules (crlf, hangul, extend, spacing mark, prepend)
  function automatic logic pair_joins(gcb_pkg::prop_t a, gcb_pkg::prop_t b);
    logic j;
    j = 1'b0;
    if (a == gcb_pkg::P_CR) j = (b == gcb_pkg::P_LF);
    else if (a inside {gcb_pkg::P_CONTROL, gcb_pkg::P_LF}) j = 1'b0;
    else if (extend_like(b) || b == gcb_pkg::P_SPACING) j = 1'b1;
    else if (a == gcb_pkg::P_PREPEND)
      j = !(b inside {gcb_pkg::P_CONTROL, gcb_pkg::P_CR, gcb_pkg::P_LF});
    else if (a == gcb_pkg::P_HL)
      j = b inside {gcb_pkg::P_HL, gcb_pkg::P_HV, gcb_pkg::P_HLV, gcb_pkg::P_HLVT};
    else if (a inside {gcb_pkg::P_HV, gcb_pkg::P_HLV})
      j = b inside {gcb_pkg::P_HV, gcb_pkg::P_HT};
    else if (a inside {gcb_pkg::P_HT, gcb_pkg::P_HLVT}) j = (b == gcb_pkg::P_HT);
    return j;
  endfunction

  function automatic logic predict_break(gcb_pkg::prop_t raw, logic restart);
    gcb_pkg::prop_t       a;
    gcb_pkg::prop_t       b;
    logic                 zf;
    logic                 rf;
    logic                 keep;
    gcb_pkg::conj_level_e lvl;
    b = (raw >= gcb_pkg::PROP_COUNT) ? gcb_pkg::P_OTHER : raw;
    a = last_prop;
    if (!last_valid || restart) begin
      last_prop  = b;
      last_valid = 1'b1;
      zwj_open   = 1'b0;
      ri_open    = 1'b0;
      conj_lvl   = gcb_pkg::LVL_NONE;
      return 1'b1;
    end
    // emoji zwj context
    if (!zwj_open) zf = (a == gcb_pkg::P_EXT_PICT) && extend_like(b);
    else if (a inside {gcb_pkg::P_ZWJ, gcb_pkg::P_ZWJ_ICB_EXT}) zf = (b == gcb_pkg::P_EXT_PICT);
    else if (a inside {gcb_pkg::P_EXTEND, gcb_pkg::P_EXT_ICB_EXT, gcb_pkg::P_EXT_ICB_LINK,
                       gcb_pkg::P_EXT_PICT}) zf = extend_like(b);
    else zf = 1'b0;
    rf = !ri_open && a == gcb_pkg::P_RI && b == gcb_pkg::P_RI;
    // conjunct level follows the left property
    if (a == gcb_pkg::P_ICB_CONS) lvl = gcb_pkg::LVL_CONS;
    else if (a inside {gcb_pkg::P_ICB_EXT, gcb_pkg::P_ZWJ_ICB_EXT, gcb_pkg::P_EXT_ICB_EXT})
      lvl = (conj_lvl == gcb_pkg::LVL_NONE) ? gcb_pkg::LVL_NONE
          : ((conj_lvl == gcb_pkg::LVL_LINKED) ? gcb_pkg::LVL_LINKED : gcb_pkg::LVL_EXT);
    else if (a inside {gcb_pkg::P_ICB_LINK, gcb_pkg::P_EXT_ICB_LINK})
      lvl = (conj_lvl == gcb_pkg::LVL_NONE) ? gcb_pkg::LVL_NONE : gcb_pkg::LVL_LINKED;
    else lvl = gcb_pkg::LVL_NONE;
    keep = pair_joins(a, b)
         || (lvl == gcb_pkg::LVL_LINKED && b == gcb_pkg::P_ICB_CONS)
         || (zf && a inside {gcb_pkg::P_ZWJ, gcb_pkg::P_ZWJ_ICB_EXT}
             && b == gcb_pkg::P_EXT_PICT)
         || rf;
    if (!keep) begin
      zf = 1'b0;
      rf = 1'b0;
    end
    last_prop = b;
    zwj_open  = zf;
    ri_open   = rf;
    conj_lvl  = lvl;
    return !keep;
  endfunction

  function automatic gcb_pkg::prop_t pick2(gcb_pkg::prop_t x, gcb_pkg::prop_t y);
    return ($urandom_range(0, 1) != 0) ? x : y;
  endfunction

  function automatic gcb_pkg::prop_t pick3(gcb_pkg::prop_t x, gcb_pkg::prop_t y,
                                           gcb_pkg::prop_t z);
    case ($urandom_range(0, 2))
      0: return x;
      1: return y;
      default: return z;
    endcase
  endfunction

  task automatic push_cp(gcb_pkg::prop_t p);
    stim_q.push_back('{p, ($urandom_range(0, 99) < RESTART_PCT), EXP_MODEL});
  endtask

  task automatic push_run(gcb_pkg::prop_t x, gcb_pkg::prop_t y, gcb_pkg::prop_t z,
                          int unsigned max_len);
    int unsigned n;
    n = $urandom_range(0, max_len);
    repeat (n) push_cp(pick3(x, y, z));
  endtask

  // mostly well-formed clusters with random content, the rest noise
  task automatic build_random();
    while (stim_q.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          push_cp(gcb_pkg::P_EXT_PICT);
          push_run(gcb_pkg::P_EXTEND, gcb_pkg::P_EXT_ICB_EXT, gcb_pkg::P_EXT_ICB_LINK, 2);
          push_cp(pick2(gcb_pkg::P_ZWJ, gcb_pkg::P_ZWJ_ICB_EXT));
          push_cp(gcb_pkg::P_EXT_PICT);
        end
        2: begin
          push_run(gcb_pkg::P_RI, gcb_pkg::P_RI, gcb_pkg::P_RI, 5);
          push_cp(gcb_pkg::P_RI);
        end
        3: begin
          push_run(gcb_pkg::P_HL, gcb_pkg::P_HL, gcb_pkg::P_HL, 2);
          push_cp(pick3(gcb_pkg::P_HV, gcb_pkg::P_HLV, gcb_pkg::P_HLVT));
          push_run(gcb_pkg::P_HV, gcb_pkg::P_HV, gcb_pkg::P_HV, 2);
          push_run(gcb_pkg::P_HT, gcb_pkg::P_HT, gcb_pkg::P_HT, 2);
        end
        4, 5: begin
          push_cp(gcb_pkg::P_ICB_CONS);
          push_run(gcb_pkg::P_ICB_EXT, gcb_pkg::P_EXT_ICB_EXT, gcb_pkg::P_ZWJ_ICB_EXT, 2);
          push_cp(pick2(gcb_pkg::P_ICB_LINK, gcb_pkg::P_EXT_ICB_LINK));
          push_run(gcb_pkg::P_ICB_EXT, gcb_pkg::P_ICB_LINK, gcb_pkg::P_EXT_ICB_EXT, 2);
          push_cp(gcb_pkg::P_ICB_CONS);
        end
        6: begin
          push_cp(gcb_pkg::P_CR);
          push_cp(($urandom_range(0, 1) != 0) ? gcb_pkg::P_LF
                  : pick3(gcb_pkg::P_CONTROL, gcb_pkg::P_LF, gcb_pkg::P_OTHER));
        end
        7: begin
          push_cp(gcb_pkg::P_PREPEND);
          push_cp(gcb_pkg::prop_t'($urandom_range(0, 31)));
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_cp(gcb_pkg::prop_t'($urandom_range(0, 31)));
        end
      endcase
    end
  endtask

  function automatic logic calm();
    return n_accepted >= CALM_FIRST && n_accepted < CALM_LAST;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // source: a new transaction only once the current one is taken
  always @(posedge clk_i) begin : feed
    cp_item_t item;
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (stim_q.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        item = stim_q.pop_front();
        in_valid_i  <= 1'b1;
        next_prop_i <= item.prop;
        restart_i   <= item.restart;
        feed_src    <= item.src;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : predict
    logic brk;
    if (rst_ni && in_valid_i && in_ready_o) begin
      brk = predict_break(next_prop_i, restart_i);
      if (feed_src == EXP_BREAK) brk = 1'b1;
      else if (feed_src == EXP_JOIN) brk = 1'b0;
      break_q.push_back(brk);
      n_accepted <= n_accepted + 1;
    end
  end

  always @(posedge clk_i) begin : check
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (break_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual break_before %0b",
                 $time, break_before_o);
        n_errors++;
      end else begin
        want = break_q.pop_front();
        if (break_before_o !== want) begin
          $display("%0t: break_before mismatch, expected %0b, actual %0b",
                   $time, want, break_before_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    next_prop_i = gcb_pkg::P_OTHER;
    restart_i   = 1'b0;
    out_ready_i = 1'b0;
    feed_src    = EXP_MODEL;
    n_accepted  = 0;
    n_cycles    = 0;
    n_errors    = 0;
    last_prop   = gcb_pkg::P_OTHER;
    last_valid  = 1'b0;
    zwj_open    = 1'b0;
    ri_open     = 1'b0;
    conj_lvl    = gcb_pkg::LVL_NONE;
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    build_random();
    total_items = stim_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (n_accepted != total_items || break_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
